FILE: hdl/iale_pkg.sv
`timescale 1ns / 1ps

package iale_pkg;

    // fixed widths of the channel fields
    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int POS2_W  = 4;
    localparam int VALUE_W = 32;
    localparam int FOUND_W = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET     = 3'd0,
        KIND_SET     = 3'd1,
        KIND_INSERT  = 3'd2,
        KIND_DELETE  = 3'd3,
        KIND_FIND    = 3'd4,
        KIND_SWAP    = 3'd5,
        KIND_REVERSE = 3'd6,
        KIND_CLEAR   = 3'd7
    } kind_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GET_RD,
        ST_GET_CAP,
        ST_INS_STEP,
        ST_INS_WR,
        ST_DEL_RD0,
        ST_DEL_CAP,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_SW_RA,
        ST_SW_RB,
        ST_SW_WA,
        ST_SW_WB,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] read_value;
        logic [FOUND_W-1:0] found_position;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

FILE: hdl/iale_ram.sv
`timescale 1ns / 1ps

module iale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/iale_ctrl.sv
`timescale 1ns / 1ps

module iale_ctrl import iale_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // command word
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [KIND_W-1:0]        cmd_kind,
    input  logic [POS_W-1:0]         cmd_position,
    input  logic [POS2_W-1:0]        cmd_other_position,
    input  logic signed [VALUE_W-1:0] cmd_value,
    // result word
    output logic                     res_valid,
    input  logic                     res_ready,
    output result_t                  res,
    // entry memory
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [WORD_BITS-1:0]     mem_wdata,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    input  logic [WORD_BITS-1:0]     mem_rdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS2_W-1:0]    pos2_reg, pos2_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [IDX_W-1:0]     a_reg, a_next;
    logic [IDX_W-1:0]     b_reg, b_next;
    logic [WORD_BITS-1:0] hold_reg, hold_next;
    logic                 ok_reg, ok_next;
    logic [VALUE_W-1:0]   rdv_reg, rdv_next;
    logic [FOUND_W-1:0]   fnd_reg, fnd_next;

    logic [CMP_W-1:0] pos_x, pos2_x, n_x;
    logic             pos_in, pos2_in, ins_ok, k_at_pos;
    logic [IDX_W-1:0] pos_idx, pos2_idx, k_idx;
    logic [CNT_W-1:0] k_plus, k_minus;
    logic [IDX_W-1:0] a_plus, b_minus;
    logic             rev_more, del_more, find_more, match;

    assign pos_x     = CMP_W'(pos_reg);
    assign pos2_x    = CMP_W'(pos2_reg);
    assign n_x       = CMP_W'(fill_reg);
    assign pos_in    = pos_x < n_x;
    assign pos2_in   = pos2_x < n_x;
    assign ins_ok    = (fill_reg != CNT_W'(DEPTH)) && (pos_x <= n_x);
    assign pos_idx   = IDX_W'(pos_reg);
    assign pos2_idx  = IDX_W'(pos2_reg);
    assign k_idx     = k_reg[IDX_W-1:0];
    assign k_plus    = k_reg + 1'b1;
    assign k_minus   = k_reg - 1'b1;
    assign k_at_pos  = CMP_W'(k_reg) == pos_x;
    assign a_plus    = a_reg + 1'b1;
    assign b_minus   = b_reg - 1'b1;
    assign rev_more  = (kind_reg == KIND_REVERSE) && (a_plus < b_minus);
    assign del_more  = k_plus < fill_reg;
    assign find_more = k_reg < fill_reg;
    assign match     = mem_rdata == word_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (kind_reg)
                    KIND_GET:     state_next = pos_in ? ST_GET_RD : ST_DONE;
                    KIND_INSERT:  state_next = ins_ok ? ST_INS_STEP : ST_DONE;
                    KIND_DELETE:  state_next = pos_in ? ST_DEL_RD0 : ST_DONE;
                    KIND_FIND:    state_next = ST_FIND_RD;
                    KIND_SWAP:    state_next = (pos_in && pos2_in) ? ST_SW_RA : ST_DONE;
                    KIND_REVERSE: state_next = (fill_reg > CNT_W'(1)) ? ST_SW_RA : ST_DONE;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_GET_RD:   state_next = ST_GET_CAP;
            ST_GET_CAP:  state_next = ST_DONE;
            ST_INS_STEP: state_next = k_at_pos ? ST_DONE : ST_INS_WR;
            ST_INS_WR:   state_next = ST_INS_STEP;
            ST_DEL_RD0:  state_next = ST_DEL_CAP;
            ST_DEL_CAP:  state_next = ST_DEL_RD;
            ST_DEL_RD:   state_next = del_more ? ST_DEL_WR : ST_DONE;
            ST_DEL_WR:   state_next = ST_DEL_RD;
            ST_FIND_RD:  state_next = find_more ? ST_FIND_CMP : ST_DONE;
            ST_FIND_CMP: state_next = match ? ST_DONE : ST_FIND_RD;
            ST_SW_RA:    state_next = ST_SW_RB;
            ST_SW_RB:    state_next = ST_SW_WA;
            ST_SW_WA:    state_next = ST_SW_WB;
            ST_SW_WB:    state_next = rev_more ? ST_SW_RA : ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // handshake and memory port controls
    always_comb begin
        cmd_ready = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = k_idx;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = k_idx;
        case (state_reg)
            ST_IDLE: cmd_ready = 1'b1;
            ST_DECODE: begin
                if (kind_reg == KIND_SET && pos_in) begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_idx;
                    mem_wdata = word_reg;
                end
            end
            ST_GET_RD, ST_DEL_RD0: begin
                mem_re    = 1'b1;
                mem_raddr = pos_idx;
            end
            ST_INS_STEP: begin
                if (k_at_pos) begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_idx;
                    mem_wdata = word_reg;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = k_minus[IDX_W-1:0];
                end
            end
            ST_INS_WR, ST_DEL_WR: mem_we = 1'b1;
            ST_DEL_RD: begin
                mem_re    = del_more;
                mem_raddr = k_plus[IDX_W-1:0];
            end
            ST_FIND_RD: mem_re = find_more;
            ST_SW_RA: begin
                mem_re    = 1'b1;
                mem_raddr = a_reg;
            end
            ST_SW_RB: begin
                mem_re    = 1'b1;
                mem_raddr = b_reg;
            end
            ST_SW_WA: begin
                mem_we    = 1'b1;
                mem_waddr = a_reg;
            end
            ST_SW_WB: begin
                mem_we    = 1'b1;
                mem_waddr = b_reg;
                mem_wdata = hold_reg;
            end
            ST_DONE: res_valid = 1'b1;
            default: cmd_ready = 1'b0;
        endcase
    end

    // datapath next values
    always_comb begin
        kind_next = kind_reg;
        pos_next  = pos_reg;
        pos2_next = pos2_reg;
        word_next = word_reg;
        fill_next = fill_reg;
        k_next    = k_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        hold_next = hold_reg;
        ok_next   = ok_reg;
        rdv_next  = rdv_reg;
        fnd_next  = fnd_reg;
        case (state_reg)
            ST_IDLE: begin
                kind_next = kind_t'(cmd_kind);
                pos_next  = cmd_position;
                pos2_next = cmd_other_position;
                word_next = WORD_BITS'($unsigned(cmd_value));
                ok_next   = 1'b0;
                rdv_next  = '0;
                fnd_next  = '0;
            end
            ST_DECODE: begin
                case (kind_reg)
                    KIND_SET:    ok_next = pos_in;
                    KIND_INSERT: begin
                        if (ins_ok) begin
                            ok_next   = 1'b1;
                            k_next    = fill_reg;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    KIND_DELETE: ok_next = pos_in;
                    KIND_FIND:   k_next = '0;
                    KIND_SWAP: begin
                        ok_next = pos_in && pos2_in;
                        a_next  = pos_idx;
                        b_next  = pos2_idx;
                    end
                    KIND_REVERSE: begin
                        ok_next = 1'b1;
                        a_next  = '0;
                        b_next  = IDX_W'(fill_reg - 1'b1);
                    end
                    KIND_CLEAR: begin
                        ok_next   = 1'b1;
                        fill_next = '0;
                    end
                    default: ok_next = 1'b0;
                endcase
            end
            ST_GET_CAP: begin
                ok_next  = 1'b1;
                rdv_next = VALUE_W'(mem_rdata);
            end
            ST_INS_WR: k_next = k_minus;
            ST_DEL_CAP: begin
                rdv_next = VALUE_W'(mem_rdata);
                k_next   = CNT_W'(pos_reg);
            end
            ST_DEL_RD: begin
                if (!del_more) begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            ST_DEL_WR: k_next = k_plus;
            ST_FIND_CMP: begin
                if (match) begin
                    ok_next  = 1'b1;
                    fnd_next = FOUND_W'(k_reg);
                end else begin
                    k_next = k_plus;
                end
            end
            ST_SW_RB: hold_next = mem_rdata;
            ST_SW_WB: begin
                if (rev_more) begin
                    a_next = a_plus;
                    b_next = b_minus;
                end
            end
            default: k_next = k_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        pos_reg  <= pos_next;
        pos2_reg <= pos2_next;
        word_reg <= word_next;
        k_reg    <= k_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        hold_reg <= hold_next;
        ok_reg   <= ok_next;
        rdv_reg  <= rdv_next;
        fnd_reg  <= fnd_next;
    end

    assign res.ok             = ok_reg;
    assign res.read_value     = rdv_reg;
    assign res.found_position = fnd_reg;
    assign res.count          = COUNT_W'(fill_reg);

    // single port discipline: never a read and a write in the same cycle
    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("read and write issued together");

    // writes only land inside the held part of the list
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (CNT_W'(mem_waddr) < fill_reg))
        else $error("write beyond fill count");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // the count moves by one, or drops to zero on clear
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(fill_reg) |-> (fill_reg == $past(fill_reg) + 1'b1 ||
                                fill_reg == $past(fill_reg) - 1'b1 ||
                                fill_reg == '0))
        else $error("fill count jumped");

endmodule

FILE: hdl/indexed_array_list_engine_unit.sv
`timescale 1ns / 1ps

// channel  | direction | ports                                              | handshake
// s_       | in        | s_kind, s_position, s_other_position, s_value     | s_valid / s_ready
// m_       | out       | m_ok, m_read_value, m_found_position, m_count     | m_valid / m_ready
//
// one command word at a time; the next word is taken only after the result has gone to the output register
// the controller uses the one entry memory for one read or one write a cycle, with registered read data
// reset clears the fill count, the controller state and the output valid flag; the entry memory is never cleared
// the result sits in an output register, so a new word is taken while m_ready is held low

module indexed_array_list_engine_unit import iale_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [KIND_W-1:0]         s_kind,
    input  logic [POS_W-1:0]          s_position,
    input  logic [POS2_W-1:0]         s_other_position,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_ok,
    output logic signed [VALUE_W-1:0] m_read_value,
    output logic [FOUND_W-1:0]        m_found_position,
    output logic [COUNT_W-1:0]        m_count
);

    localparam int IDX_W = $clog2(DEPTH);

    // controller to output register
    result_t res;
    logic    res_valid;
    logic    res_ready;

    // entry memory port
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    // output register
    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    iale_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd_valid          (s_valid),
        .cmd_ready          (s_ready),
        .cmd_kind           (s_kind),
        .cmd_position       (s_position),
        .cmd_other_position (s_other_position),
        .cmd_value          (s_value),
        .res_valid          (res_valid),
        .res_ready          (res_ready),
        .res                (res),
        .mem_we             (mem_we),
        .mem_waddr          (mem_waddr),
        .mem_wdata          (mem_wdata),
        .mem_re             (mem_re),
        .mem_raddr          (mem_raddr),
        .mem_rdata          (mem_rdata)
    );

    iale_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // the output register takes a new result when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_ok             = m_res_reg.ok;
    assign m_read_value     = $signed(m_res_reg.read_value);
    assign m_found_position = m_res_reg.found_position;
    assign m_count          = m_res_reg.count;

endmodule

FILE: tb/indexed_array_list_engine_unit_tb.sv
`timescale 1ns / 1ps

module indexed_array_list_engine_unit_tb;
    import iale_pkg::*;

    localparam int LIST_DEPTH = 16;

    // clock starts low so the first edge seen is a rising one
    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [KIND_W-1:0]         s_kind;
    logic [POS_W-1:0]          s_position;
    logic [POS2_W-1:0]         s_other_position;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_ok;
    logic signed [VALUE_W-1:0] m_read_value;
    logic [FOUND_W-1:0]        m_found_position;
    logic [COUNT_W-1:0]        m_count;

    // mirror of the list as the block should hold it
    logic [VALUE_W-1:0] list_words [LIST_DEPTH];
    int                 list_len;

    // results still owed by the block, oldest first
    result_t pending_results [$];

    // when low, neither side inserts idle cycles
    logic idle_on;
    int   ready_stall_left;

    int failures;
    int n_sent;
    int n_checked;
    int n_rejected;
    int n_full_inserts;
    int n_find_hits;

    indexed_array_list_engine_unit #(
        .DEPTH     (LIST_DEPTH),
        .WORD_BITS (VALUE_W)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_position       (s_position),
        .s_other_position (s_other_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_read_value     (m_read_value),
        .m_found_position (m_found_position),
        .m_count          (m_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // idle length: mostly short, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // data words biased towards extremes and small repeats so find sees duplicates
    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4, 5: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // expected-result queue: append at the tail, take from the head
    function automatic void add_expected(result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic result_t take_expected();
        result_t r;

        r = pending_results[0];
        pending_results.delete(0);
        return r;
    endfunction

    // expected result of one command; updates the mirrored list as the block should
    function automatic result_t predict_list_command(kind_t kind, logic [POS_W-1:0] pos,
                                                     logic [POS2_W-1:0] pos2,
                                                     logic [VALUE_W-1:0] word);
        result_t            r;
        int                 n;
        int                 k;
        int                 lo;
        int                 hi;
        logic [VALUE_W-1:0] held;

        r = '0;
        n = list_len;
        case (kind)
            KIND_GET: begin
                if (pos < n) begin
                    r.ok = 1'b1;
                    r.read_value = list_words[pos];
                end
            end
            KIND_SET: begin
                if (pos < n) begin
                    list_words[pos] = word;
                    r.ok = 1'b1;
                end
            end
            KIND_INSERT: begin
                // rejected when full or when the index lies past the end
                if (n < LIST_DEPTH && pos <= n) begin
                    for (k = n; k > pos; k--) begin
                        list_words[k] = list_words[k-1];
                    end
                    list_words[pos] = word;
                    list_len = n + 1;
                    r.ok = 1'b1;
                end
            end
            KIND_DELETE: begin
                if (pos < n) begin
                    r.read_value = list_words[pos];
                    for (k = pos; k + 1 < n; k++) begin
                        list_words[k] = list_words[k+1];
                    end
                    list_len = n - 1;
                    r.ok = 1'b1;
                end
            end
            KIND_FIND: begin
                // lowest matching index wins
                for (k = 0; k < n; k++) begin
                    if (list_words[k] == word) begin
                        break;
                    end
                end
                if (k < n) begin
                    r.ok = 1'b1;
                    r.found_position = k[FOUND_W-1:0];
                end
            end
            KIND_SWAP: begin
                if (pos < n && pos2 < n) begin
                    held = list_words[pos];
                    list_words[pos] = list_words[pos2];
                    list_words[pos2] = held;
                    r.ok = 1'b1;
                end
            end
            KIND_REVERSE: begin
                lo = 0;
                hi = n - 1;
                while (lo < hi) begin
                    held = list_words[lo];
                    list_words[lo] = list_words[hi];
                    list_words[hi] = held;
                    lo++;
                    hi--;
                end
                r.ok = 1'b1;
            end
            default: begin
                list_len = 0;
                r.ok = 1'b1;
            end
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    // one command word: optional idle, drive at the falling edge, wait for the handshake
    task automatic send_list_command(kind_t kind, logic [POS_W-1:0] pos,
                                     logic [POS2_W-1:0] pos2, logic [VALUE_W-1:0] word);
        int      gap;
        result_t expected;

        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid          = 1'b1;
        s_kind           = kind;
        s_position       = pos;
        s_other_position = pos2;
        s_value          = word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);

        // word taken at this edge: work out what it must return
        if (kind == KIND_INSERT && list_len == LIST_DEPTH) n_full_inserts++;
        expected = predict_list_command(kind, pos, pos2, word);
        add_expected(expected);
        n_sent++;
        if (!expected.ok) n_rejected++;
        if (kind == KIND_FIND && expected.ok) n_find_hits++;
    endtask

    // drop valid first so the word just taken is not offered again while waiting
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic note_mismatch(string what, result_t want, result_t got);
        if (failures < 10) begin
            $display("%0t %s: want ok=%0b rd=%h fp=%0d n=%0d got ok=%0b rd=%h fp=%0d n=%0d",
                     $realtime, what, want.ok, want.read_value, want.found_position, want.count,
                     got.ok, got.read_value, got.found_position, got.count);
        end
        failures++;
    endtask

    // result side: random back-pressure, drawn at the falling edge
    always @(negedge aclk) begin
        if (ready_stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
            ready_stall_left = pick_gap();
        end
        if (ready_stall_left > 0) begin
            m_ready = 1'b0;
            ready_stall_left--;
        end else begin
            m_ready = 1'b1;
        end
    end

    // result checker: each word taken is matched against the oldest prediction
    always @(posedge aclk) begin
        result_t got;
        result_t want;

        if (aresetn && m_valid && m_ready) begin
            got.ok             = m_ok;
            got.read_value     = m_read_value;
            got.found_position = m_found_position;
            got.count          = m_count;
            if (pending_results.size() == 0) begin
                note_mismatch("result word with nothing outstanding", '0, got);
            end else begin
                want = take_expected();
                n_checked++;
                if (got.ok !== want.ok || got.read_value !== want.read_value ||
                    got.found_position !== want.found_position || got.count !== want.count) begin
                    note_mismatch("result word differs", want, got);
                end
            end
        end
    end

    // every command against an empty list, and an insert beyond the end
    task automatic test_empty_list();
        send_list_command(KIND_GET, 5'd0, 4'd0, 32'h0);
        send_list_command(KIND_SET, 5'd0, 4'd0, 32'h1111_1111);
        send_list_command(KIND_DELETE, 5'd0, 4'd0, 32'h0);
        send_list_command(KIND_FIND, 5'd0, 4'd0, 32'h0);
        send_list_command(KIND_SWAP, 5'd0, 4'd0, 32'h0);
        send_list_command(KIND_REVERSE, 5'd0, 4'd0, 32'h0);
        send_list_command(KIND_CLEAR, 5'd0, 4'd0, 32'h0);
        send_list_command(KIND_INSERT, 5'd1, 4'd0, 32'h2222_2222);
    endtask

    // extreme words at the front, middle and back, then reads at the boundaries
    task automatic test_edge_values();
        send_list_command(KIND_INSERT, 5'd0, 4'd0, 32'h8000_0000);
        send_list_command(KIND_INSERT, 5'd1, 4'd0, 32'h7fff_ffff);
        send_list_command(KIND_INSERT, 5'd0, 4'd0, 32'hffff_ffff);
        send_list_command(KIND_INSERT, 5'd1, 4'd0, 32'h0000_0000);
        send_list_command(KIND_GET, 5'd31, 4'd15, 32'h0);
        send_list_command(KIND_GET, 5'd3, 4'd0, 32'h0);
        send_list_command(KIND_INSERT, 5'd16, 4'd0, 32'h3333_3333);
    endtask

    task automatic test_search_and_reorder();
        send_list_command(KIND_SET, 5'd3, 4'd0, 32'h5555_5555);
        send_list_command(KIND_FIND, 5'd0, 4'd0, 32'h7fff_ffff);
        send_list_command(KIND_FIND, 5'd0, 4'd0, 32'h1234_5678);
        send_list_command(KIND_SWAP, 5'd0, 4'd15, 32'h0);
        send_list_command(KIND_SWAP, 5'd3, 4'd0, 32'h0);
        send_list_command(KIND_REVERSE, 5'd0, 4'd0, 32'h0);
    endtask

    task automatic test_delete_and_clear();
        send_list_command(KIND_DELETE, 5'd4, 4'd0, 32'h0);
        send_list_command(KIND_DELETE, 5'd0, 4'd0, 32'h0);
        send_list_command(KIND_DELETE, 5'd2, 4'd0, 32'h0);
        send_list_command(KIND_CLEAR, 5'd0, 4'd0, 32'h0);
        // hold the sender until the block has answered everything
        wait_results_drained();
    endtask

    // sessions: fill the list to a random length (sometimes past full), then mixed commands
    task automatic test_random_sessions(int target);
        int                 sessions;
        int                 goal_len;
        int                 ops;
        int                 i;
        int                 pick;
        kind_t              kind;
        logic [POS_W-1:0]   pos;
        logic [POS2_W-1:0]  pos2;
        logic [VALUE_W-1:0] word;

        sessions = 0;
        while (n_sent < target) begin
            sessions++;
            // every fifth session runs with no idling on either side
            idle_on = (sessions % 5 != 0);
            if (sessions % 7 == 0) wait_results_drained();
            if ($urandom_range(0, 1) == 1) begin
                send_list_command(KIND_CLEAR, POS_W'($urandom_range(0, 31)),
                                  POS2_W'($urandom_range(0, 15)), $urandom);
            end

            goal_len = ($urandom_range(0, 3) == 0) ? LIST_DEPTH + 2
                                                   : $urandom_range(0, LIST_DEPTH - 1);
            for (i = list_len; i < goal_len; i++) begin
                send_list_command(KIND_INSERT, POS_W'($urandom_range(0, list_len)),
                                  POS2_W'($urandom_range(0, 15)), pick_word());
            end

            ops = $urandom_range(10, 40);
            for (i = 0; i < ops; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    // noise: any field value at all
                    send_list_command(kind_t'($urandom_range(0, 7)), POS_W'($urandom_range(0, 31)),
                                      POS2_W'($urandom_range(0, 15)), $urandom);
                end else begin
                    kind = kind_t'($urandom_range(0, 7));
                    if (kind == KIND_CLEAR && $urandom_range(0, 3) != 0) kind = KIND_GET;
                    if (list_len > 0 && $urandom_range(0, 9) != 0) begin
                        pos  = (kind == KIND_INSERT) ? POS_W'($urandom_range(0, list_len))
                                                     : POS_W'($urandom_range(0, list_len - 1));
                        pos2 = POS2_W'($urandom_range(0, list_len - 1));
                    end else begin
                        pos  = POS_W'($urandom_range(0, 31));
                        pos2 = POS2_W'($urandom_range(0, 15));
                    end
                    if (kind == KIND_FIND && list_len > 0 && $urandom_range(0, 9) < 7) begin
                        word = list_words[$urandom_range(0, list_len - 1)];
                    end else begin
                        word = pick_word();
                    end
                    send_list_command(kind, pos, pos2, word);
                end
            end
        end
    endtask

    // watchdog
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        // every input known from time zero
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_kind           = KIND_GET;
        s_position       = '0;
        s_other_position = '0;
        s_value          = '0;
        m_ready          = 1'b0;
        ready_stall_left = 0;
        idle_on          = 1'b1;
        list_len         = 0;
        failures         = 0;
        n_sent           = 0;
        n_checked        = 0;
        n_rejected       = 0;
        n_full_inserts   = 0;
        n_find_hits      = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_list();
        test_edge_values();
        test_search_and_reorder();
        test_delete_and_clear();
        test_random_sessions(1100);

        @(negedge aclk);
        s_valid = 1'b0;
        wait_results_drained();
        // the longest commands are a find miss and a delete at the head of a full list, well inside this
        repeat (64) @(posedge aclk);
        failures += pending_results.size();

        $display("covered %0d command words and %0d result words", n_sent, n_checked);
        $display("with %0d rejected commands, %0d inserts into a full list, %0d find hits",
                 n_rejected, n_full_inserts, n_find_hits);
        if (failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
